FILE: rtl/core/spd_pkg.sv
// ----------------------------------------------------------------------------
// SSH-1 packet deframer package
// Shared types and constants for the deframer core and its channel
// interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    // Field widths of the channels and the length accumulator
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MAX_LEN_W  = 19;
    localparam int unsigned PLEN_W     = 18;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned ACC_W      = 24;

    // Reset value of the length limit register
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 19'd262144;

    // Packet constants
    localparam logic [BYTE_W-1:0] TYPE_DEBUG  = 8'd36;
    localparam logic [BYTE_W-1:0] TYPE_IGNORE = 8'd32;
    localparam logic [31:0]       MIN_LEN     = 32'd5;
    localparam logic [3:0]        PAD_BASE    = 4'd8;
    localparam logic [2:0]        CRC_BYTES   = 3'd4;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // Framing phases, one-hot
    typedef enum logic [4:0] {
        PH_LEN     = 5'b00001,
        PH_PAD     = 5'b00010,
        PH_TYPE    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CRC     = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

FILE: rtl/core/spd_byte_if.sv
// ----------------------------------------------------------------------------
// SSH-1 deframer byte channel
// Valid/ready channel carrying one received plaintext byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_byte_if;

    logic                          valid;
    logic                          ready;
    logic [spd_pkg::BYTE_W-1:0]    in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/spd_res_if.sv
// ----------------------------------------------------------------------------
// SSH-1 deframer result channel
// Valid/ready channel carrying one header, payload or error result per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_res_if;

    logic                          valid;
    logic                          ready;
    spd_pkg::t_kind                kind;
    logic [spd_pkg::BYTE_W-1:0]    msg_type;
    logic [spd_pkg::PLEN_W-1:0]    payload_len;
    logic [spd_pkg::BYTE_W-1:0]    data_byte;
    logic                          last;

    modport source (output valid, output kind, output msg_type, output payload_len,
                    output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input msg_type, input payload_len,
                    input data_byte, input last, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/spd_cfg_if.sv
// ----------------------------------------------------------------------------
// SSH-1 deframer configuration channel
// Valid/ready write channel for the maximum packet length register.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_cfg_if;

    logic                            valid;
    logic                            ready;
    logic [spd_pkg::MAX_LEN_W-1:0]   max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/ssh1_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// SSH-1 packet deframer core
// Splits a decrypted SSH-1 binary packet byte stream into packet headers,
// payload bytes and bad length errors.
// ----------------------------------------------------------------------------
// The core takes one plaintext byte per cycle and gives at most one result
// per byte, in the cycle after the byte is taken. Every byte is handled
// by the framing state machine and a small length check, so the core
// sustains one byte per clock; input ready drops only while a result sits
// in the output register and the sink is not taking it. Each
// packet is a 4-byte big-endian length L, 8 - (L mod 8) padding bytes, a
// type byte, L-5 payload bytes and 4 CRC bytes. A header result carries the
// type and L-5, each payload byte follows with last set on the final one;
// padding and CRC are dropped unchecked. Debug and ignore packets give no
// results. A length below 5, above max_length or above LENGTH_LIMIT gives one
// error result and the next byte starts a fresh length. Write max_length only
// while the core is idle.
`default_nettype none

module ssh1_packet_deframer_core #(
    parameter int unsigned LENGTH_LIMIT = 262144
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    spd_cfg_if.sink    i_cfg,
    spd_byte_if.sink   i_in,
    spd_res_if.source  o_res
);

    // Byte counter wide enough for LENGTH_LIMIT-5 payload bytes and the CRC
    localparam int unsigned BL_W = $clog2(LENGTH_LIMIT);

    // Configuration register
    logic [spd_pkg::MAX_LEN_W-1:0] r_max_length;

    // Framing state
    spd_pkg::t_phase               r_phase,      n_phase;
    logic [spd_pkg::ACC_W-1:0]     r_len_acc,    n_len_acc;
    logic [1:0]                    r_len_cnt,    n_len_cnt;
    logic [3:0]                    r_pad_left,   n_pad_left;
    logic [BL_W-1:0]               r_bytes_left, n_bytes_left;
    logic [spd_pkg::BYTE_W-1:0]    r_cur_type,   n_cur_type;
    logic                          r_drop,       n_drop;

    // Output register
    logic                          r_out_valid;
    spd_pkg::t_kind                r_out_kind;
    logic [spd_pkg::BYTE_W-1:0]    r_out_type;
    logic [spd_pkg::PLEN_W-1:0]    r_out_plen;
    logic [spd_pkg::BYTE_W-1:0]    r_out_data;
    logic                          r_out_last;

    // Result of the current byte
    logic                          emit;
    spd_pkg::t_kind                res_kind;
    logic [spd_pkg::BYTE_W-1:0]    res_type;
    logic [spd_pkg::PLEN_W-1:0]    res_plen;
    logic [spd_pkg::BYTE_W-1:0]    res_data;
    logic                          res_last;

    logic                          in_fire;
    logic                          out_fire;
    logic [31:0]                   full_len;
    logic                          len_bad;
    logic [BL_W-1:0]               bytes_dec;
    logic [31:0]                   bytes_wide;

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = r_out_valid && o_res.ready;
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;

    // Length word completed by the fourth length byte
    assign full_len = {r_len_acc, i_in.in_byte};
    assign len_bad  = (full_len < spd_pkg::MIN_LEN)
                   || (full_len > {13'd0, r_max_length})
                   || (full_len > 32'(LENGTH_LIMIT));

    assign bytes_dec  = (r_bytes_left != '0) ? (r_bytes_left - BL_W'(1)) : r_bytes_left;
    assign bytes_wide = 32'(r_bytes_left);

    // Framing state machine and result selection
    always_comb begin
        n_phase      = r_phase;
        n_len_acc    = r_len_acc;
        n_len_cnt    = r_len_cnt;
        n_pad_left   = r_pad_left;
        n_bytes_left = r_bytes_left;
        n_cur_type   = r_cur_type;
        n_drop       = r_drop;
        emit         = 1'b0;
        res_kind     = spd_pkg::KIND_ERROR;
        res_type     = '0;
        res_plen     = '0;
        res_data     = '0;
        res_last     = 1'b0;

        unique case (r_phase)
            spd_pkg::PH_PAD: begin
                // discard padding
                n_pad_left = (r_pad_left != 4'd0) ? (r_pad_left - 4'd1) : r_pad_left;
                if (n_pad_left == 4'd0) begin
                    n_phase = spd_pkg::PH_TYPE;
                end
            end
            spd_pkg::PH_TYPE: begin
                // latch type and announce the packet
                n_cur_type = i_in.in_byte;
                n_drop     = (i_in.in_byte == spd_pkg::TYPE_DEBUG)
                          || (i_in.in_byte == spd_pkg::TYPE_IGNORE);
                if (r_bytes_left == '0) begin
                    n_phase      = spd_pkg::PH_CRC;
                    n_bytes_left = BL_W'(spd_pkg::CRC_BYTES);
                end else begin
                    n_phase = spd_pkg::PH_PAYLOAD;
                end
                emit     = !n_drop;
                res_kind = spd_pkg::KIND_HEADER;
                res_type = i_in.in_byte;
                res_plen = bytes_wide[spd_pkg::PLEN_W-1:0];
            end
            spd_pkg::PH_PAYLOAD: begin
                // pass payload through, mark the final byte
                n_bytes_left = bytes_dec;
                res_last     = (bytes_dec == '0);
                if (res_last) begin
                    n_phase      = spd_pkg::PH_CRC;
                    n_bytes_left = BL_W'(spd_pkg::CRC_BYTES);
                end
                emit     = !r_drop;
                res_kind = spd_pkg::KIND_PAYLOAD;
                res_type = r_cur_type;
                res_data = i_in.in_byte;
            end
            spd_pkg::PH_CRC: begin
                // skip the CRC
                n_bytes_left = bytes_dec;
                if (bytes_dec == '0) begin
                    n_phase = spd_pkg::PH_LEN;
                end
            end
            default: begin
                // gather the big-endian length
                if (r_len_cnt != 2'd3) begin
                    n_len_cnt = r_len_cnt + 2'd1;
                    n_len_acc = (r_len_cnt == 2'd0)
                              ? {16'd0, i_in.in_byte}
                              : {r_len_acc[15:0], i_in.in_byte};
                    n_phase   = spd_pkg::PH_LEN;
                end else begin
                    n_len_cnt = 2'd0;
                    n_len_acc = full_len[spd_pkg::ACC_W-1:0];
                    if (len_bad) begin
                        n_phase  = spd_pkg::PH_LEN;
                        emit     = 1'b1;
                        res_kind = spd_pkg::KIND_ERROR;
                    end else begin
                        n_phase      = spd_pkg::PH_PAD;
                        n_pad_left   = spd_pkg::PAD_BASE - {1'b0, full_len[2:0]};
                        n_bytes_left = BL_W'(full_len - spd_pkg::MIN_LEN);
                    end
                end
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= spd_pkg::MAX_LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_length <= i_cfg.max_length;
        end
    end

    // Advance framing state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= spd_pkg::PH_LEN;
            r_len_acc    <= '0;
            r_len_cnt    <= 2'd0;
            r_pad_left   <= 4'd0;
            r_bytes_left <= '0;
            r_cur_type   <= '0;
            r_drop       <= 1'b0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_len_acc    <= n_len_acc;
            r_len_cnt    <= n_len_cnt;
            r_pad_left   <= n_pad_left;
            r_bytes_left <= n_bytes_left;
            r_cur_type   <= n_cur_type;
            r_drop       <= n_drop;
        end
    end

    // Output valid: load on a result, drop once the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: hold until replaced
    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_out_kind <= res_kind;
            r_out_type <= res_type;
            r_out_plen <= res_plen;
            r_out_data <= res_data;
            r_out_last <= res_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.msg_type    = r_out_type;
    assign o_res.payload_len = r_out_plen;
    assign o_res.data_byte   = r_out_data;
    assign o_res.last        = r_out_last;

    // Payload phase always has bytes still to come
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == spd_pkg::PH_PAYLOAD |-> r_bytes_left != '0)
        else $error("payload phase with no bytes left");

    // Padding count stays within one to eight
    a_pad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == spd_pkg::PH_PAD |-> (r_pad_left != 4'd0 && r_pad_left <= 4'd8))
        else $error("padding count out of range");

    // Error results carry no type or length
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == spd_pkg::KIND_ERROR)
        |-> (r_out_type == '0 && r_out_plen == '0 && !r_out_last))
        else $error("error result with stray fields");

    // Last marker only on payload results
    a_last_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_out_kind == spd_pkg::KIND_PAYLOAD)
        else $error("last marker on a non-payload result");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// SSH-1 packet deframer core testbench
// Streams framed byte sequences with random content into the deframer and
// checks every header, payload and bad length result against an in-bench
// prediction of the framing state machine. Idling on both channels is random
// until the last phase; the length limit is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int unsigned          BYTE_W        = spd_pkg::BYTE_W;
    localparam int unsigned          MAX_LEN_W     = spd_pkg::MAX_LEN_W;
    localparam int unsigned          PLEN_W        = spd_pkg::PLEN_W;
    localparam int unsigned          FRAME_LIMIT   = 262144;
    localparam int                   SETTLE_CYCLES = 8;
    localparam int                   MAX_REPORTS   = 10;
    localparam logic [MAX_LEN_W-1:0] REG_TOP       = '1;

    typedef struct packed {
        spd_pkg::t_kind     kind;
        logic [BYTE_W-1:0]  msg_type;
        logic [PLEN_W-1:0]  payload_len;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } t_frame_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spd_cfg_if  cfg_if ();
    spd_byte_if byte_if ();
    spd_res_if  res_if ();

    ssh1_packet_deframer_core #(
        .LENGTH_LIMIT (FRAME_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (byte_if),
        .o_res   (res_if)
    );

    // Stream still to be sent and results still owed by the core
    logic [BYTE_W-1:0] rx_stream[$];
    t_frame_res        due_results[$];

    int          fail_count  = 0;
    bit          byte_taken  = 1'b0;
    bit          idle_enable = 1'b1;
    int          send_gap    = 0;
    int          send_calm   = 0;
    int          sink_gap    = 0;
    int          sink_calm   = 0;
    logic [31:0] gen_limit;

    // Predicted framing state
    spd_pkg::t_phase      fr_phase;
    logic [31:0]          fr_len_acc;
    logic [1:0]           fr_len_count;
    logic [3:0]           fr_pad_left;
    logic [MAX_LEN_W-1:0] fr_bytes_left;
    logic [BYTE_W-1:0]    fr_type;
    logic                 fr_drop;
    logic [MAX_LEN_W-1:0] fr_max_len;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the framing prediction by one byte, queueing any result it owes
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        t_frame_res res;
        logic       fin;
        res = '0;
        case (fr_phase)
            spd_pkg::PH_PAD: begin
                if (fr_pad_left != 4'd0) fr_pad_left--;
                if (fr_pad_left == 4'd0) fr_phase = spd_pkg::PH_TYPE;
            end
            spd_pkg::PH_TYPE: begin
                fr_type         = b;
                fr_drop         = (b == spd_pkg::TYPE_DEBUG) || (b == spd_pkg::TYPE_IGNORE);
                res.kind        = spd_pkg::KIND_HEADER;
                res.msg_type    = b;
                res.payload_len = fr_bytes_left[PLEN_W-1:0];
                if (fr_bytes_left == '0) begin
                    fr_phase      = spd_pkg::PH_CRC;
                    fr_bytes_left = MAX_LEN_W'(spd_pkg::CRC_BYTES);
                end else begin
                    fr_phase = spd_pkg::PH_PAYLOAD;
                end
                if (!fr_drop) due_results.push_back(res);
            end
            spd_pkg::PH_PAYLOAD: begin
                if (fr_bytes_left != '0) fr_bytes_left--;
                fin = (fr_bytes_left == '0);
                if (fin) begin
                    fr_phase      = spd_pkg::PH_CRC;
                    fr_bytes_left = MAX_LEN_W'(spd_pkg::CRC_BYTES);
                end
                if (!fr_drop) begin
                    res.kind      = spd_pkg::KIND_PAYLOAD;
                    res.msg_type  = fr_type;
                    res.data_byte = b;
                    res.last      = fin;
                    due_results.push_back(res);
                end
            end
            spd_pkg::PH_CRC: begin
                if (fr_bytes_left != '0) fr_bytes_left--;
                if (fr_bytes_left == '0) fr_phase = spd_pkg::PH_LEN;
            end
            default: begin
                // Gather the big-endian length, check it on the fourth byte
                if (fr_len_count == 2'd0) fr_len_acc = {24'd0, b};
                else fr_len_acc = {fr_len_acc[23:0], b};
                if (fr_len_count < 2'd3) begin
                    fr_len_count++;
                    fr_phase = spd_pkg::PH_LEN;
                end else begin
                    fr_len_count = 2'd0;
                    if (fr_len_acc < spd_pkg::MIN_LEN || fr_len_acc > {13'd0, fr_max_len} ||
                        fr_len_acc > FRAME_LIMIT) begin
                        fr_phase = spd_pkg::PH_LEN;
                        res.kind = spd_pkg::KIND_ERROR;
                        due_results.push_back(res);
                    end else begin
                        fr_pad_left   = spd_pkg::PAD_BASE - {1'b0, fr_len_acc[2:0]};
                        fr_bytes_left = MAX_LEN_W'(fr_len_acc - spd_pkg::MIN_LEN);
                        fr_phase      = spd_pkg::PH_PAD;
                    end
                end
            end
        endcase
    endtask

    // Track transactions on all three channels and check each result
    always @(posedge i_clk) begin
        t_frame_res want;
        if (!i_rst_n) begin
            fr_phase      = spd_pkg::PH_LEN;
            fr_len_acc    = '0;
            fr_len_count  = '0;
            fr_pad_left   = '0;
            fr_bytes_left = '0;
            fr_type       = '0;
            fr_drop       = 1'b0;
            fr_max_len    = spd_pkg::MAX_LEN_RESET;
            byte_taken    = 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) fr_max_len = cfg_if.max_length;
            byte_taken = byte_if.valid && byte_if.ready;
            if (byte_taken) deframe_byte(byte_if.in_byte);
            if (res_if.valid && res_if.ready) begin
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: kind %0d type %0d len %0d data %0d last %0d",
                                 res_if.kind, res_if.msg_type, res_if.payload_len,
                                 res_if.data_byte, res_if.last);
                end else begin
                    want = due_results.pop_front();
                    if (res_if.kind !== want.kind || res_if.msg_type !== want.msg_type ||
                        res_if.payload_len !== want.payload_len ||
                        res_if.data_byte !== want.data_byte || res_if.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("result mismatch: expected kind %0d type %0d len %0d data %0d last %0d",
                                     want.kind, want.msg_type, want.payload_len,
                                     want.data_byte, want.last);
                            $display("                 got kind %0d type %0d len %0d data %0d last %0d",
                                     res_if.kind, res_if.msg_type, res_if.payload_len,
                                     res_if.data_byte, res_if.last);
                        end
                    end
                end
            end
        end
    end

    // Feed the byte channel from the stream queue, with bursts of idling
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else if (!byte_if.valid || byte_taken) begin
            if (send_calm != 0) send_calm--;
            else if ($urandom_range(0, 150) == 0) send_calm = $urandom_range(30, 120);
            if (send_gap != 0) begin
                send_gap--;
                byte_if.valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
                if (idle_enable && send_calm == 0 && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    byte_if.valid <= 1'b0;
                end else begin
                    byte_if.valid   <= 1'b1;
                    byte_if.in_byte <= rx_stream.pop_front();
                end
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result channel in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (sink_calm != 0) sink_calm--;
            else if ($urandom_range(0, 150) == 0) sink_calm = $urandom_range(30, 120);
            if (sink_gap != 0) begin
                sink_gap--;
                res_if.ready <= 1'b0;
            end else if (idle_enable && sink_calm == 0 && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(0, 3);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic bit length_fits(input logic [31:0] len);
        return len >= spd_pkg::MIN_LEN && len <= gen_limit && len <= FRAME_LIMIT;
    endfunction

    // Queue one packet; a length the core will refuse goes out without a body
    task automatic queue_packet(input logic [31:0] len, input logic [BYTE_W-1:0] type_byte);
        for (int i = 3; i >= 0; i--) rx_stream.push_back(len[8*i +: 8]);
        if (length_fits(len)) begin
            repeat (8 - int'(len[2:0])) rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
            rx_stream.push_back(type_byte);
            repeat (len - spd_pkg::MIN_LEN)
                rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
            repeat (spd_pkg::CRC_BYTES) rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Queue mostly well-formed packets, mixed with refused lengths
    task automatic queue_traffic(input int n_bytes);
        int                target;
        int                pick;
        logic [31:0]       len;
        logic [31:0]       ceiling;
        logic [BYTE_W-1:0] type_byte;
        target  = rx_stream.size() + n_bytes;
        ceiling = (gen_limit < FRAME_LIMIT) ? gen_limit : FRAME_LIMIT;
        while (rx_stream.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) len = $urandom_range(5, 24);
            else if (pick < 65) len = $urandom_range(25, 120);
            else if (pick < 72) len = $urandom_range(121, 400);
            else if (pick < 80) len = (ceiling <= 400 && $urandom_range(0, 1) != 0) ?
                                      ceiling : spd_pkg::MIN_LEN;
            else if (pick < 86) len = $urandom_range(0, 4);
            else if (pick < 93) len = ceiling + 1 + $urandom_range(0, 40);
            else len = {8'($urandom_range(1, 255)), 24'($urandom())};
            if (pick < 80 && len > ceiling) len = ceiling;
            pick = $urandom_range(0, 99);
            if (pick < 10) type_byte = spd_pkg::TYPE_DEBUG;
            else if (pick < 16) type_byte = spd_pkg::TYPE_IGNORE;
            else type_byte = BYTE_W'($urandom_range(0, 255));
            queue_packet(len, type_byte);
        end
    endtask

    // Hold the sender until every owed result has come and the core is quiet
    task automatic settle();
        while (rx_stream.size() != 0 || byte_if.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [MAX_LEN_W-1:0] value);
        settle();
        @(negedge i_clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.max_length <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        gen_limit = 32'(value);
    endtask

    initial begin
        byte_if.valid     = 1'b0;
        byte_if.in_byte   = '0;
        res_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.max_length = '0;
        gen_limit         = 32'(spd_pkg::MAX_LEN_RESET);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty payload, field extremes, full padding, dropped types
        queue_packet(32'd5, 8'd0);
        queue_packet(32'd6, 8'd255);
        queue_packet(32'd8, spd_pkg::TYPE_DEBUG);
        queue_packet(32'd5, spd_pkg::TYPE_IGNORE);
        queue_packet(32'd0, 8'd1);
        queue_packet(32'd4, 8'd1);
        queue_packet(32'hFFFF_FFFF, 8'd1);
        queue_packet(FRAME_LIMIT + 1, 8'd1);
        queue_packet(32'd15, 8'd20);

        // A limit under the minimum refuses every length
        write_max_length(19'd4);
        queue_packet(32'd5, 8'd7);
        queue_packet(32'd4, 8'd7);

        // Tightest usable limit
        write_max_length(19'd5);
        queue_packet(32'd5, 8'd9);
        queue_packet(32'd6, 8'd9);

        // Register above the core limit: the core limit governs
        write_max_length(REG_TOP);
        queue_packet(FRAME_LIMIT + 1, 8'd3);
        queue_traffic(500);

        write_max_length(19'd300);
        queue_traffic(500);

        // Finish at the reset value with no idling
        write_max_length(spd_pkg::MAX_LEN_RESET);
        idle_enable = 1'b0;
        queue_traffic(600);
        settle();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
